// ===== sv/udp_flow_origin_table_top_assert.svh =====
`ifndef UDP_FLOW_ORIGIN_TABLE_TOP_ASSERT_SVH
`define UDP_FLOW_ORIGIN_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define UFOT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define UFOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ufot_pkg.sv =====
package ufot_pkg;

  localparam int BUCKET_COUNT    = 2048;
  localparam int WAYS_PER_BUCKET = 4;
  localparam int BUCKET_W        = $clog2(BUCKET_COUNT);
  localparam int WAY_W           = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic        valid;
    logic        family;
    logic [15:0] port;
    logic [31:0] src_v4;
    logic [63:0] src_v6_high;
    logic [63:0] src_v6_low;
    logic [31:0] dest_v4;
    logic [63:0] dest_v6_high;
    logic [63:0] dest_v6_low;
    logic [15:0] dest_port;
    logic [31:0] pid;
  } entry_t;

  typedef entry_t [WAYS_PER_BUCKET-1:0] row_t;

endpackage

// ===== sv/ufot_req_if.sv =====
interface ufot_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        is_ipv6;
  logic [31:0] source_v4;
  logic [63:0] source_v6_high;
  logic [63:0] source_v6_low;
  logic [15:0] source_port;
  logic [31:0] dest_v4_in;
  logic [63:0] dest_v6_high_in;
  logic [63:0] dest_v6_low_in;
  logic [15:0] dest_port_in;
  logic [31:0] process_id_in;

  modport source (
    output valid, operation, is_ipv6, source_v4, source_v6_high, source_v6_low,
           source_port, dest_v4_in, dest_v6_high_in, dest_v6_low_in, dest_port_in,
           process_id_in,
    input  ready
  );

  modport sink (
    input  valid, operation, is_ipv6, source_v4, source_v6_high, source_v6_low,
           source_port, dest_v4_in, dest_v6_high_in, dest_v6_low_in, dest_port_in,
           process_id_in,
    output ready
  );
endinterface

// ===== sv/ufot_rsp_if.sv =====
interface ufot_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] dest_v4_out;
  logic [63:0] dest_v6_high_out;
  logic [63:0] dest_v6_low_out;
  logic [15:0] dest_port_out;
  logic [31:0] process_id_out;

  modport source (
    output valid, status, dest_v4_out, dest_v6_high_out, dest_v6_low_out,
           dest_port_out, process_id_out,
    input  ready
  );

  modport sink (
    input  valid, status, dest_v4_out, dest_v6_high_out, dest_v6_low_out,
           dest_port_out, process_id_out,
    output ready
  );
endinterface

// ===== sv/udp_flow_origin_table_top.sv =====
// UDP flow origin table: maps a source endpoint (family, port, address) to the
// original destination address, port and process id, in 2048 buckets of 4 ways
// held as one row per bucket in a single-port-read, single-port-write memory.
// A lookup or put reads the bucket row on the accepting edge; once the result
// register is free, the evaluate state compares all ways, registers the result
// and, for a put that fits, writes the row back. One item is in work at a time.
// A clear walks the memory one row per cycle and then posts its result. After
// reset the block runs the same clearing pass, with ready low, before it takes
// its first beat. The result register lets the block take a new beat while the
// previous result is still waiting to be taken.
module udp_flow_origin_table_top (
  input logic clk,
  input logic rst,
  ufot_req_if.sink   req,
  ufot_rsp_if.source rsp
);
  import ufot_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;

  logic [1:0] state;
  logic [BUCKET_W-1:0] clr_cnt;
  logic clr_report;

  row_t mem [BUCKET_COUNT];
  row_t rd_row;
  logic wr_en;
  logic [BUCKET_W-1:0] wr_addr;
  row_t wr_row;

  // Captured item.
  logic [1:0]  op_q;
  logic        fam_q;
  logic [31:0] sv4_q;
  logic [63:0] sv6h_q;
  logic [63:0] sv6l_q;
  logic [15:0] sport_q;
  logic [31:0] dv4_q;
  logic [63:0] dv6h_q;
  logic [63:0] dv6l_q;
  logic [15:0] dport_q;
  logic [31:0] pid_q;

  logic accept;
  logic out_free;
  logic eval_fire;

  logic hit_found;
  logic [WAY_W-1:0] hit_way;
  logic free_found;
  logic [WAY_W-1:0] free_way;
  entry_t hit_entry;
  entry_t upd_entry;
  entry_t ins_entry;
  row_t row_mod;
  logic [2:0] status_next;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign eval_fire = (state == S_EVAL) && out_free;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= mem[req.source_port[BUCKET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.operation;
      fam_q   <= req.is_ipv6;
      sv4_q   <= req.source_v4;
      sv6h_q  <= req.source_v6_high;
      sv6l_q  <= req.source_v6_low;
      sport_q <= req.source_port;
      dv4_q   <= req.dest_v4_in;
      dv6h_q  <= req.dest_v6_high_in;
      dv6l_q  <= req.dest_v6_low_in;
      dport_q <= req.dest_port_in;
      pid_q   <= req.process_id_in;
    end else if ((state == S_CLEAR) && (clr_cnt == BUCKET_W'(BUCKET_COUNT - 1))) begin
      op_q <= OP_CLEAR;
    end
  end

  // Lowest matching way and lowest free way of the bucket.
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
      if (rd_row[w].valid && rd_row[w].port == sport_q && rd_row[w].family == fam_q &&
          (fam_q ? (rd_row[w].src_v6_high == sv6h_q && rd_row[w].src_v6_low == sv6l_q)
                 : (rd_row[w].src_v4 == sv4_q))) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (!rd_row[w].valid) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    hit_entry           = rd_row[hit_way];
    upd_entry           = hit_entry;
    upd_entry.dest_v4   = dv4_q;
    upd_entry.dest_port = dport_q;
    upd_entry.pid       = pid_q;
    // The stored IPv6 destination survives an update through an IPv4 key.
    if (fam_q) begin
      upd_entry.dest_v6_high = dv6h_q;
      upd_entry.dest_v6_low  = dv6l_q;
    end
    ins_entry = '{valid: 1'b1, family: fam_q, port: sport_q, src_v4: sv4_q,
                  src_v6_high: sv6h_q, src_v6_low: sv6l_q, dest_v4: dv4_q,
                  dest_v6_high: dv6h_q, dest_v6_low: dv6l_q, dest_port: dport_q,
                  pid: pid_q};
    row_mod = rd_row;
    if (hit_found) begin
      row_mod[hit_way] = upd_entry;
    end else begin
      row_mod[free_way] = ins_entry;
    end
  end

  always_comb begin
    case (op_q)
      OP_LOOKUP: status_next = hit_found ? ST_HIT : ST_MISS;
      OP_PUT:    status_next = hit_found ? ST_UPDATED : (free_found ? ST_INSERTED : ST_FULL);
      OP_CLEAR:  status_next = ST_CLEARED;
      default:   status_next = ST_MISS;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sport_q[BUCKET_W-1:0];
    wr_row  = row_mod;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_row  = '0;
    end else if (eval_fire && (op_q == OP_PUT) && (hit_found || free_found)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.operation == OP_CLEAR) begin
              state      <= S_CLEAR;
              clr_cnt    <= '0;
              clr_report <= 1'b1;
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + BUCKET_W'(1);
          if (clr_cnt == BUCKET_W'(BUCKET_COUNT - 1)) begin
            state <= clr_report ? S_EVAL : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (eval_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      rsp.status <= status_next;
      if (op_q == OP_LOOKUP && hit_found) begin
        rsp.dest_v4_out      <= hit_entry.dest_v4;
        rsp.dest_v6_high_out <= hit_entry.dest_v6_high;
        rsp.dest_v6_low_out  <= hit_entry.dest_v6_low;
        rsp.dest_port_out    <= hit_entry.dest_port;
        rsp.process_id_out   <= hit_entry.pid;
      end else begin
        rsp.dest_v4_out      <= '0;
        rsp.dest_v6_high_out <= '0;
        rsp.dest_v6_low_out  <= '0;
        rsp.dest_port_out    <= '0;
        rsp.process_id_out   <= '0;
      end
    end
  end

endmodule

// ===== sv/ufot_checker.sv =====
`include "udp_flow_origin_table_top_assert.svh"

module ufot_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] dest_v4_out,
  input logic [63:0] dest_v6_high_out,
  input logic [63:0] dest_v6_low_out,
  input logic [15:0] dest_port_out,
  input logic [31:0] process_id_out
);
  import ufot_pkg::*;

  logic data_zero;

  assign data_zero = (dest_v4_out == '0) && (dest_v6_high_out == '0) &&
                     (dest_v6_low_out == '0) && (dest_port_out == '0) &&
                     (process_id_out == '0);

  // A result beat stays offered until it is taken.
  `UFOT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

  // One item is in work at a time, so a beat is never followed directly by another.
  `UFOT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "ready high after a beat")

  `UFOT_ASSERT_NOW(a_status_code, out_valid, status <= ST_CLEARED, "status out of range")

  // Only a hit carries stored values.
  `UFOT_ASSERT_NOW(a_zero_data, out_valid && (status != ST_HIT), data_zero,
                   "nonzero data on a result other than a hit")

endmodule

bind udp_flow_origin_table_top ufot_checker u_ufot_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (req.valid),
  .in_ready         (req.ready),
  .out_valid        (rsp.valid),
  .out_ready        (rsp.ready),
  .status           (rsp.status),
  .dest_v4_out      (rsp.dest_v4_out),
  .dest_v6_high_out (rsp.dest_v6_high_out),
  .dest_v6_low_out  (rsp.dest_v6_low_out),
  .dest_port_out    (rsp.dest_port_out),
  .process_id_out   (rsp.process_id_out)
);
